>>> hdl/uvs_pkg.sv
// shared constants, tables, types and arithmetic helpers for the uv sphere vertex generator
package uvs_pkg;

  // grid and table sizes
  localparam int MAX_TESS   = 64;
  localparam int TESS_MIN   = 3;
  localparam int SINE_DEPTH = 256;
  localparam int SINE_AW    = $clog2(SINE_DEPTH);
  localparam int PH_W       = SINE_AW + 2;

  // field widths
  localparam int TESS_W   = 7;
  localparam int ROW_W    = 7;
  localparam int COL_W    = 8;
  localparam int RADIUS_W = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_AW   = 1;
  localparam int MAG_W    = 16;
  localparam int POS_W    = 17;
  localparam int NORM_W   = 16;
  localparam int TEX_W    = 17;
  localparam int IDX_W    = 14;

  // stream widths
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_FIELDS_W = 3 * POS_W + 3 * NORM_W + 2 * TEX_W + 2 * IDX_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // texture coordinate scaling
  localparam int TEX_ONE     = 65536;
  localparam int TEX_SHIFT_U = 16;
  localparam int TEX_SHIFT_V = 17;

  // reciprocal division by 2t: exact for numerators below 2**NUM_W
  localparam int NUM_W     = $clog2(((2 * MAX_TESS) << TEX_SHIFT_U) + MAX_TESS + 1);
  localparam int DIV_L     = $clog2(2 * MAX_TESS);
  localparam int DIV_SHIFT = NUM_W + DIV_L;
  localparam int RECIP_W   = DIV_SHIFT - 2;
  localparam int QUO_W     = NUM_W + RECIP_W - DIV_SHIFT;

  // q1.15 rounding and limits
  localparam int                 Q15_HALF = 1 << 14;
  localparam logic [MAG_W-1:0]   Q15_MAX  = MAG_W'((1 << 15) - 1);
  localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;

  // configuration register indexes and reset values
  localparam logic [CFG_AW-1:0]   REG_RADIUS   = CFG_AW'(0);
  localparam logic [CFG_AW-1:0]   REG_TESS     = CFG_AW'(1);
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(256);
  localparam logic [TESS_W-1:0]   TESS_RESET   = TESS_W'(3);

  typedef logic [MAG_W-1:0]   sine_tab_t  [0:SINE_DEPTH];
  typedef logic [RECIP_W-1:0] recip_tab_t [0:MAX_TESS];

  // quarter-wave sine, q1.15 with 1.0 as 32768, integer taylor series
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] q;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      x    = (HALF_PI_Q30 * 64'(k) + 64'(SINE_DEPTH / 2)) / 64'(SINE_DEPTH);
      x2   = (x * x + (64'd1 << 29)) >> 30;
      term = ((x * x2) >> 30) / 64'd6;
      sum  = x - term;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd210;
      sum  = sum - term;
      q    = (sum + 64'd16384) >> 15;
      if (q > 64'd32768) begin
        q = 64'd32768;
      end
      tab[k] = MAG_W'(q);
    end
    return tab;
  endfunction

  // floor(2**(DIV_SHIFT-1) / t) + 1, so that (n * m) >> DIV_SHIFT == n / (2t)
  function automatic recip_tab_t build_recip_tab();
    recip_tab_t  tab;
    logic [63:0] dv;
    logic [63:0] rem;
    logic [63:0] quo;
    for (int t = 0; t <= MAX_TESS; t++) begin
      dv  = (t < TESS_MIN) ? 64'(TESS_MIN) : 64'(t);
      rem = '0;
      quo = '0;
      // restoring long division, dividend has only its top bit set
      for (int b = DIV_SHIFT - 1; b >= 0; b--) begin
        rem = {rem[62:0], (b == DIV_SHIFT - 1)};
        quo = {quo[62:0], 1'b0};
        if (rem >= dv) begin
          rem    = rem - dv;
          quo[0] = 1'b1;
        end
      end
      tab[t] = RECIP_W'(quo + 64'd1);
    end
    return tab;
  endfunction

  localparam sine_tab_t  SINE_TAB  = build_sine_tab();
  localparam recip_tab_t RECIP_TAB = build_recip_tab();

  // sign and magnitude q1.15, magnitude up to 32768
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } smag_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } s1_t;

  typedef struct packed {
    logic [PH_W-1:0]  lat_ph;
    logic [PH_W-1:0]  lon_ph;
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] quo_v;
    logic [IDX_W-1:0] row_base;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] col_next;
    logic             has_quad;
  } s2_t;

  typedef struct packed {
    smag_t            dxz;
    smag_t            dy;
    smag_t            sin_lon;
    smag_t            cos_lon;
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
    logic [IDX_W-1:0] vertex_index;
    logic [IDX_W-1:0] right_index;
    logic             has_quad;
  } s3_t;

  typedef struct packed {
    smag_t            dx;
    smag_t            dy;
    smag_t            dz;
    logic [MAG_W-1:0] pos_y_mag;
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
    logic [IDX_W-1:0] vertex_index;
    logic [IDX_W-1:0] right_index;
    logic             has_quad;
  } s4_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
    logic        [TEX_W-1:0]  tex_u;
    logic        [TEX_W-1:0]  tex_v;
    logic        [IDX_W-1:0]  vertex_index;
    logic        [IDX_W-1:0]  right_index;
    logic                     has_quad;
  } vtx_t;

  // full-turn phase to signed sine via quarter-wave symmetry
  function automatic smag_t sine_lookup(input logic [PH_W-1:0] phase);
    smag_t              r;
    logic [SINE_AW-1:0] idx;
    logic [SINE_AW:0]   addr;
    idx = phase[SINE_AW-1:0];
    if (phase[SINE_AW]) begin
      addr = (SINE_AW + 1)'(SINE_DEPTH) - {1'b0, idx};
    end else begin
      addr = {1'b0, idx};
    end
    r.mag = SINE_TAB[addr];
    r.neg = phase[SINE_AW + 1];
    return r;
  endfunction

  // magnitude product shifted by 15, rounded half up
  function automatic logic [MAG_W-1:0] mul_q15(input logic [MAG_W-1:0] a,
                                               input logic [MAG_W-1:0] b);
    logic [2*MAG_W-1:0] p;
    p = a * b + (2 * MAG_W)'(Q15_HALF);
    return p[MAG_W+14:15];
  endfunction

  // n / (2t) through the reciprocal of t
  function automatic logic [QUO_W-1:0] recip_div(input logic [NUM_W-1:0]   n,
                                                 input logic [RECIP_W-1:0] m);
    logic [NUM_W+RECIP_W-1:0] p;
    p = n * m;
    return p[NUM_W+RECIP_W-1:DIV_SHIFT];
  endfunction

endpackage

>>> hdl/uv_sphere_vertex_generator_unit.sv
// top level of the uv sphere vertex generator: config registers, stage control, stream ports
// a beat moves through s1, s2, s3, s4 and vtx, which drives m_axis; m_axis_tready low stalls it
// throughput: one beat per cycle unless stalled; five register stages, each advancing when free
// the longest stage is the reciprocal multiply (24 x 29 bits) that divides by twice the band count
// reset (rst, synchronous): clears every stage valid bit, radius back to 256, bands back to 3
// sine and reciprocal tables are constant logic, so no clearing pass follows reset
module uv_sphere_vertex_generator_unit import uvs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  // configuration write port
  input  logic                    cfg_we,
  input  logic [CFG_AW-1:0]       cfg_addr,
  input  logic [CFG_W-1:0]        cfg_wdata,
  // grid point in
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [IN_TDATA_W-1:0]   s_axis_tdata,  // lat_row, lon_col
  // vertex out
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [OUT_TDATA_W-1:0]  m_axis_tdata,  // pos_x, pos_y, pos_z, norm_x, norm_y,
                                                 // norm_z, tex_u, tex_v, vertex_index,
                                                 // right_index
  output logic                    m_axis_tuser   // has_quad
);

  localparam int NUM_STAGES = 5;

  logic [RADIUS_W-1:0]   radius;
  logic [TESS_W-1:0]     tess;
  logic [TESS_W-1:0]     tess_wr;
  logic [RECIP_W-1:0]    recip;
  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES:0]   ready;
  stage_en_t             en;
  s2_t                   s2;
  s3_t                   s3;
  vtx_t                  vtx;

  // band count is saturated into range as it is written, so the datapath never sees it raw
  always_comb begin
    tess_wr = cfg_wdata[TESS_W-1:0];
    if (tess_wr < TESS_W'(TESS_MIN)) begin
      tess_wr = TESS_W'(TESS_MIN);
    end else if (tess_wr > TESS_W'(MAX_TESS)) begin
      tess_wr = TESS_W'(MAX_TESS);
    end
  end

  // the reciprocal of t is looked up at write time and held beside t
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
      tess   <= TESS_RESET;
      recip  <= RECIP_TAB[TESS_RESET];
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RADIUS: begin
          radius <= cfg_wdata[RADIUS_W-1:0];
        end
        REG_TESS: begin
          tess  <= tess_wr;
          recip <= RECIP_TAB[tess_wr];
        end
        default: begin
        end
      endcase
    end
  end

  // a stage takes a new beat when it is empty or its contents move on this cycle,
  // so bubbles close up and the input keeps flowing while the output waits
  always_comb begin
    ready[NUM_STAGES] = m_axis_tready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      ready[k] = ~valid[k] | ready[k + 1];
    end
  end

  assign en.s1 = ready[0];
  assign en.s2 = ready[1];
  assign en.s3 = ready[2];
  assign en.s4 = ready[3];
  assign en.s5 = ready[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[0]) begin
        valid[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (ready[k]) begin
          valid[k] <= valid[k - 1];
        end
      end
    end
  end

  // stages one and two: clamp, phase and texture quotients, row base
  uvs_grid_front u_front (
    .clk     (clk),
    .en      (en),
    .lat_row (s_axis_tdata[ROW_W-1:0]),
    .lon_col (s_axis_tdata[ROW_W+COL_W-1:ROW_W]),
    .tess    (tess),
    .recip   (recip),
    .s2      (s2)
  );

  // stage three: sine and cosine of both angles, indices
  uvs_trig_stage u_trig (
    .clk (clk),
    .en  (en),
    .s2  (s2),
    .s3  (s3)
  );

  // stage four: unit direction and y scaling; stage five: x and z scaling into the output register
  uvs_scale_stage u_scale (
    .clk    (clk),
    .en     (en),
    .radius (radius),
    .s3     (s3),
    .vtx    (vtx)
  );

  assign s_axis_tready = ready[0];
  assign m_axis_tvalid = valid[NUM_STAGES - 1];
  assign m_axis_tuser  = vtx.has_quad;
  assign m_axis_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0),
                          vtx.right_index, vtx.vertex_index,
                          vtx.tex_v, vtx.tex_u,
                          vtx.norm_z, vtx.norm_y, vtx.norm_x,
                          vtx.pos_z, vtx.pos_y, vtx.pos_x};

endmodule

>>> hdl/uvs_grid_front.sv
// grid front end: index clamping, phase and texture division, row base
module uvs_grid_front import uvs_pkg::*; (
  input  logic                clk,
  input  stage_en_t           en,
  input  logic [ROW_W-1:0]    lat_row,
  input  logic [COL_W-1:0]    lon_col,
  input  logic [TESS_W-1:0]   tess,
  input  logic [RECIP_W-1:0]  recip,
  output s2_t                 s2
);

  s1_t                      s1;
  s1_t                      s1_next;
  s2_t                      s2_next;
  logic [COL_W-1:0]         twice_t;
  logic [COL_W-1:0]         stride;
  logic [NUM_W-1:0]         n_lat;
  logic [NUM_W-1:0]         n_lon;
  logic [NUM_W-1:0]         n_u;
  logic [NUM_W-1:0]         n_v;
  logic [QUO_W-1:0]         q_lat;
  logic [QUO_W-1:0]         q_lon;
  logic [QUO_W-1:0]         q_u;
  logic [QUO_W-1:0]         q_v;
  logic [ROW_W+COL_W-1:0]   row_prod;

  assign twice_t = {tess, 1'b0};
  assign stride  = twice_t + COL_W'(1);

  // saturate row to t and column to 2t
  always_comb begin
    s1_next.row = (lat_row > tess) ? tess : lat_row;
    s1_next.col = (lon_col > twice_t) ? twice_t : lon_col;
  end

  // numerators carry +t so the quotient by 2t rounds half up
  always_comb begin
    n_lat    = (NUM_W'(s1.row) << PH_W) + NUM_W'(tess);
    n_lon    = (NUM_W'(s1.col) << PH_W) + NUM_W'(tess);
    n_u      = (NUM_W'(s1.col) << TEX_SHIFT_U) + NUM_W'(tess);
    n_v      = (NUM_W'(s1.row) << TEX_SHIFT_V) + NUM_W'(tess);
    q_lat    = recip_div(n_lat, recip);
    q_lon    = recip_div(n_lon, recip);
    q_u      = recip_div(n_u, recip);
    q_v      = recip_div(n_v, recip);
    row_prod = (ROW_W + COL_W)'(s1.row) * (ROW_W + COL_W)'(stride);

    s2_next.lat_ph   = q_lat[PH_W-1:0];
    s2_next.lon_ph   = q_lon[PH_W-1:0];   // a full turn wraps to zero
    s2_next.tex_u    = q_u[TEX_W-1:0];
    s2_next.quo_v    = q_v[TEX_W-1:0];
    s2_next.row_base = row_prod[IDX_W-1:0];
    s2_next.col      = s1.col;
    s2_next.col_next = (s1.col == twice_t) ? '0 : s1.col + COL_W'(1);
    s2_next.has_quad = (s1.row < tess);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      s1 <= s1_next;
    end
    if (en.s2) begin
      s2 <= s2_next;
    end
  end

endmodule

>>> hdl/uvs_trig_stage.sv
// trig stage: quarter-wave sine lookups, texture v and vertex indices
module uvs_trig_stage import uvs_pkg::*; (
  input  logic       clk,
  input  stage_en_t  en,
  input  s2_t        s2,
  output s3_t        s3
);

  s3_t             s3_next;
  smag_t           lat_cos;
  logic [PH_W-1:0] lat_cos_ph;
  logic [PH_W-1:0] lon_cos_ph;

  always_comb begin
    lat_cos_ph = s2.lat_ph + PH_W'(SINE_DEPTH);
    lon_cos_ph = s2.lon_ph + PH_W'(SINE_DEPTH);
    lat_cos    = sine_lookup(lat_cos_ph);

    s3_next.dxz          = sine_lookup(s2.lat_ph);
    s3_next.dy.mag       = lat_cos.mag;
    s3_next.dy.neg       = ~lat_cos.neg;
    s3_next.sin_lon      = sine_lookup(s2.lon_ph);
    s3_next.cos_lon      = sine_lookup(lon_cos_ph);
    s3_next.tex_u        = s2.tex_u;
    s3_next.tex_v        = TEX_W'(TEX_ONE) - s2.quo_v;
    s3_next.vertex_index = s2.row_base + IDX_W'(s2.col);
    s3_next.right_index  = s2.row_base + IDX_W'(s2.col_next);
    s3_next.has_quad     = s2.has_quad;
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      s3 <= s3_next;
    end
  end

endmodule

>>> hdl/uvs_scale_stage.sv
// scale stages: direction products, radius scaling and signed output format
module uvs_scale_stage import uvs_pkg::*; (
  input  logic                 clk,
  input  stage_en_t            en,
  input  logic [RADIUS_W-1:0]  radius,
  input  s3_t                  s3,
  output vtx_t                 vtx
);

  s4_t              s4;
  s4_t              s4_next;
  vtx_t             vtx_next;
  logic [MAG_W-1:0] pos_x_mag;
  logic [MAG_W-1:0] pos_z_mag;

  function automatic logic signed [POS_W-1:0] to_pos(input logic neg,
                                                     input logic [MAG_W-1:0] mag);
    logic signed [POS_W-1:0] v;
    v = signed'({1'b0, mag});
    return neg ? -v : v;
  endfunction

  // +1.0 saturates to 32767, -1.0 is representable
  function automatic logic signed [NORM_W-1:0] to_norm(input smag_t d);
    logic [NORM_W-1:0] v;
    if (d.neg) begin
      v = -d.mag;
    end else begin
      v = (d.mag > Q15_MAX) ? Q15_MAX : d.mag;
    end
    return signed'(v);
  endfunction

  always_comb begin
    s4_next.dx.mag       = mul_q15(s3.dxz.mag, s3.sin_lon.mag);
    s4_next.dx.neg       = s3.dxz.neg ^ s3.sin_lon.neg;
    s4_next.dz.mag       = mul_q15(s3.dxz.mag, s3.cos_lon.mag);
    s4_next.dz.neg       = s3.dxz.neg ^ s3.cos_lon.neg;
    s4_next.dy           = s3.dy;
    s4_next.pos_y_mag    = mul_q15(radius, s3.dy.mag);
    s4_next.tex_u        = s3.tex_u;
    s4_next.tex_v        = s3.tex_v;
    s4_next.vertex_index = s3.vertex_index;
    s4_next.right_index  = s3.right_index;
    s4_next.has_quad     = s3.has_quad;
  end

  always_comb begin
    pos_x_mag = mul_q15(radius, s4.dx.mag);
    pos_z_mag = mul_q15(radius, s4.dz.mag);

    vtx_next.pos_x        = to_pos(s4.dx.neg, pos_x_mag);
    vtx_next.pos_y        = to_pos(s4.dy.neg, s4.pos_y_mag);
    vtx_next.pos_z        = to_pos(s4.dz.neg, pos_z_mag);
    vtx_next.norm_x       = to_norm(s4.dx);
    vtx_next.norm_y       = to_norm(s4.dy);
    vtx_next.norm_z       = to_norm(s4.dz);
    vtx_next.tex_u        = s4.tex_u;
    vtx_next.tex_v        = s4.tex_v;
    vtx_next.vertex_index = s4.vertex_index;
    vtx_next.right_index  = s4.right_index;
    vtx_next.has_quad     = s4.has_quad;
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      s4 <= s4_next;
    end
    if (en.s5) begin
      vtx <= vtx_next;
    end
  end

endmodule

>>> hdl/uvs_checker.sv
// port-level checker for the uv sphere vertex generator and its bind
module uvs_checker import uvs_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser
);

  logic [TEX_W-1:0] tex_v;
  logic [IDX_W-1:0] vertex_idx;
  logic [IDX_W-1:0] right_idx;

  // field positions follow the tdata packing of the top level
  assign tex_v      = m_axis_tdata[132:116];
  assign vertex_idx = m_axis_tdata[146:133];
  assign right_idx  = m_axis_tdata[160:147];

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output beat valid right after reset");

  // an empty output stage means every stage can take a beat
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output stage empty");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output beat changed");

  // the last row owns no quad and is exactly the one with v at zero
  a_quad_tex: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == (tex_v != '0)))
    else $error("quad flag disagrees with texture v");

  // right neighbour is the next index, or wraps back to the row start
  a_right_wrap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (right_idx == vertex_idx + IDX_W'(1)) || (right_idx < vertex_idx))
    else $error("right neighbour index out of row");

endmodule

bind uv_sphere_vertex_generator_unit uvs_checker u_checker (.*);
